@@ rtl/mie_pkg.sv @@
// Package: widths, controller state codes and command/status structs for the modular inverse block.
package mie_pkg;

    localparam int WORD_BITS = 64;
    localparam int CNT_BITS  = $clog2(WORD_BITS);

    typedef logic [WORD_BITS-1:0] word_t;

    typedef enum logic [6:0] {
        ST_IDLE   = 7'b0000001,
        ST_MODDIV = 7'b0000010,
        ST_MODEND = 7'b0000100,
        ST_CHK    = 7'b0001000,
        ST_STEP   = 7'b0010000,
        ST_UPD    = 7'b0100000,
        ST_FIN    = 7'b1000000
    } state_t;

    typedef struct packed {
        logic load;      // capture value, start value mod modulus
        logic div_step;  // one restoring division bit
        logic set_cur;   // remainder of the first division becomes r_cur
        logic start;     // start r_prev / r_cur
        logic update;    // advance Euclid pair and coefficients
        logic emit;      // write result register
    } dp_cmd_t;

    typedef struct packed {
        logic m_zero;
        logic rc_zero;
        logic div_last;
        logic out_busy;
    } dp_stat_t;

endpackage

@@ rtl/mie_ctrl.sv @@
// Controller: sequences the division and Euclid update steps for one transfer.
module mie_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mie_pkg::dp_stat_t stat,
    output mie_pkg::dp_cmd_t  cmd
);
    import mie_pkg::*;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = stat.m_zero ? ST_FIN : ST_MODDIV;
                end
            end
            ST_MODDIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_MODEND;
                end
            end
            ST_MODEND:
            begin
                cmd.set_cur = 1'b1;
                state_next  = ST_CHK;
            end
            ST_CHK:
            begin
                if (stat.rc_zero)
                begin
                    state_next = ST_FIN;
                end
                else
                begin
                    cmd.start  = 1'b1;
                    state_next = ST_STEP;
                end
            end
            ST_STEP:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = ST_UPD;
                end
            end
            ST_UPD:
            begin
                cmd.update = 1'b1;
                state_next = ST_CHK;
            end
            ST_FIN:
            begin
                if (!stat.out_busy)
                begin
                    cmd.emit   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

@@ rtl/mie_dp.sv @@
// Datapath: modulus register, bit-serial divider with product accumulator, Euclid registers, result register.
module mie_dp (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [mie_pkg::WORD_BITS-1:0]   cfg_wr_data,
    input  logic [mie_pkg::WORD_BITS-1:0]   value,
    input  mie_pkg::dp_cmd_t                cmd,
    output mie_pkg::dp_stat_t               stat,
    output logic                            out_valid,
    input  logic                            out_ready,
    output logic [mie_pkg::WORD_BITS-1:0]   inverse,
    output logic                            no_inverse
);
    import mie_pkg::*;

    word_t               m_reg;
    word_t               rp_reg, rp_next;
    word_t               rc_reg, rc_next;
    word_t               cp_reg, cp_next;
    word_t               cc_reg, cc_next;
    logic                np_reg, np_next;
    logic                nc_reg, nc_next;
    word_t               dn_reg, dn_next;    // dividend, shifted out MSB first
    word_t               dd_reg, dd_next;    // divisor
    word_t               dr_reg, dr_next;    // partial remainder
    word_t               pr_reg, pr_next;    // quotient times c_cur
    logic [CNT_BITS-1:0] cnt_reg, cnt_next;
    word_t               inv_reg;
    logic                fail_reg;
    logic                ov_reg;

    logic [WORD_BITS:0]  r_sh;
    logic [WORD_BITS:0]  r_sub;
    logic                qbit;
    logic                fin_fail;
    word_t               fin_inv;

    assign r_sh  = {dr_reg, dn_reg[WORD_BITS-1]};
    assign r_sub = r_sh - {1'b0, dd_reg};
    assign qbit  = !r_sub[WORD_BITS];

    assign stat.m_zero   = (m_reg == '0);
    assign stat.rc_zero  = (rc_reg == '0);
    assign stat.div_last = (cnt_reg == CNT_BITS'(WORD_BITS - 1));
    assign stat.out_busy = ov_reg && !out_ready;

    assign fin_fail = (m_reg == '0) || (rp_reg != word_t'(1));

    always_comb
    begin
        if (fin_fail || m_reg == word_t'(1))
        begin
            fin_inv = '0;
        end
        else if (np_reg && cp_reg != '0)
        begin
            fin_inv = m_reg - cp_reg;
        end
        else
        begin
            fin_inv = cp_reg;
        end
    end

    always_comb
    begin
        rp_next  = rp_reg;
        rc_next  = rc_reg;
        cp_next  = cp_reg;
        cc_next  = cc_reg;
        np_next  = np_reg;
        nc_next  = nc_reg;
        dn_next  = dn_reg;
        dd_next  = dd_reg;
        dr_next  = dr_reg;
        pr_next  = pr_reg;
        cnt_next = cnt_reg;
        if (cmd.load)
        begin
            dn_next  = value;
            dd_next  = m_reg;
            dr_next  = '0;
            pr_next  = '0;
            cnt_next = '0;
            rp_next  = m_reg;
            cp_next  = '0;
            np_next  = 1'b0;
            cc_next  = word_t'(1);
            nc_next  = 1'b0;
        end
        if (cmd.div_step)
        begin
            dr_next  = qbit ? r_sub[WORD_BITS-1:0] : r_sh[WORD_BITS-1:0];
            dn_next  = {dn_reg[WORD_BITS-2:0], 1'b0};
            pr_next  = {pr_reg[WORD_BITS-2:0], 1'b0} + (qbit ? cc_reg : '0);
            cnt_next = cnt_reg + CNT_BITS'(1);
        end
        if (cmd.set_cur)
        begin
            rc_next = dr_reg;
        end
        if (cmd.start)
        begin
            dn_next  = rp_reg;
            dd_next  = rc_reg;
            dr_next  = '0;
            pr_next  = '0;
            cnt_next = '0;
        end
        if (cmd.update)
        begin
            rp_next = rc_reg;
            rc_next = dr_reg;
            cp_next = cc_reg;
            np_next = nc_reg;
            cc_next = cp_reg + pr_reg;
            nc_next = !nc_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        rp_reg  <= rp_next;
        rc_reg  <= rc_next;
        cp_reg  <= cp_next;
        cc_reg  <= cc_next;
        np_reg  <= np_next;
        nc_reg  <= nc_next;
        dn_reg  <= dn_next;
        dd_reg  <= dd_next;
        dr_reg  <= dr_next;
        pr_reg  <= pr_next;
        cnt_reg <= cnt_next;
        if (cmd.emit)
        begin
            inv_reg  <= fin_inv;
            fail_reg <= fin_fail;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_reg  <= word_t'(1) << (WORD_BITS - 1);
            ov_reg <= 1'b0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                m_reg <= cfg_wr_data;
            end
            if (cmd.emit)
            begin
                ov_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                ov_reg <= 1'b0;
            end
        end
    end

    assign out_valid  = ov_reg;
    assign inverse    = inv_reg;
    assign no_inverse = fail_reg;

endmodule

@@ rtl/modular_inverse_euclid.sv @@
// Top level: modular inverse by the extended Euclidean algorithm.
//
//  channel   dir  data                                  handshake
//  s_axis    in   tdata[63:0] value                     tvalid/tready
//  m_axis    out  tdata[63:0] inverse, tuser no_inverse tvalid/tready
//  cfg       in   cfg_wr_data[63:0] modulus             cfg_wr_en
//
// One item at a time. Each item takes a reduction of the value mod the modulus, then k Euclid
// steps (at most 91 for 64 bits); each step is a one-bit-per-cycle division
// followed by one update and one check.
// rst_n clears the controller and sets the modulus to 2^63.
// A finished result waits in the output register; the next item is taken meanwhile,
// and the block stalls before writing a result only while the previous one is untaken.
module modular_inverse_euclid (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mie_pkg::WORD_BITS-1:0] s_axis_tdata,   // [63:0] value
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mie_pkg::WORD_BITS-1:0] m_axis_tdata,   // [63:0] inverse
    output logic                          m_axis_tuser,   // [0] no_inverse
    input  logic                          cfg_wr_en,
    input  logic [mie_pkg::WORD_BITS-1:0] cfg_wr_data     // [63:0] modulus
);
    import mie_pkg::*;

    dp_cmd_t  cmd;
    dp_stat_t stat;

    mie_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_axis_tvalid),
        .in_ready (s_axis_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mie_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .value       (s_axis_tdata),
        .cmd         (cmd),
        .stat        (stat),
        .out_valid   (m_axis_tvalid),
        .out_ready   (m_axis_tready),
        .inverse     (m_axis_tdata),
        .no_inverse  (m_axis_tuser)
    );

endmodule

@@ dv/tb_modular_inverse_euclid.sv @@
// Testbench for modular_inverse_euclid: directed and random values checked against a predictor.
`timescale 1ns / 100ps

module tb_modular_inverse_euclid;

    import mie_pkg::*;

    typedef struct packed {
        word_t inverse;
        logic  no_inverse;
    } inv_result_t;

    localparam word_t ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam word_t HALF_RANGE = 64'h8000_0000_0000_0000;
    localparam word_t FIB_93     = 64'd12200160415121876738;
    localparam word_t FIB_92     = 64'd7540113804746346429;
    localparam word_t MERSENNE61 = 64'h1FFF_FFFF_FFFF_FFFF;
    localparam int    RANDOM_ITEMS = 2000;

    logic  clk = 1'b0;
    logic  rst_n;
    logic  s_axis_tvalid;
    logic  s_axis_tready;
    word_t s_axis_tdata;      // [63:0] value
    logic  m_axis_tvalid;
    logic  m_axis_tready = 1'b0;
    word_t m_axis_tdata;      // [63:0] inverse
    logic  m_axis_tuser;      // [0] no_inverse
    logic  cfg_wr_en;
    word_t cfg_wr_data;       // [63:0] modulus

    inv_result_t inverse_q[$];
    word_t       modulus_shadow = HALF_RANGE;
    int          error_count = 0;
    int          burst_left = 0;
    int          ready_left = 0;

    modular_inverse_euclid u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Extended Euclid with sign-magnitude Bezout coefficient.
    function automatic inv_result_t modinv_predict(input word_t v, input word_t m);
        word_t       r_a, r_b, r_n, c_a, c_b, c_n, q;
        logic        neg_a, neg_b, neg_n;
        inv_result_t res;
        res = '0;
        if (m == '0)
        begin
            res.no_inverse = 1'b1;
        end
        else
        begin
            r_a   = m;
            r_b   = v % m;
            c_a   = '0;
            neg_a = 1'b0;
            c_b   = 64'd1;
            neg_b = 1'b0;
            while (r_b != '0)
            begin
                q     = r_a / r_b;
                r_n   = r_a - q * r_b;
                c_n   = c_a + q * c_b;
                neg_n = !neg_b;
                r_a   = r_b;
                r_b   = r_n;
                c_a   = c_b;
                neg_a = neg_b;
                c_b   = c_n;
                neg_b = neg_n;
            end
            if (r_a != 64'd1)
                res.no_inverse = 1'b1;
            else if (m == 64'd1)
                res.inverse = '0;
            else if (neg_a && c_a != '0)
                res.inverse = m - c_a;
            else
                res.inverse = c_a;
        end
        return res;
    endfunction

    // Sender: bursts of random length separated by random gaps.
    task automatic send_value(input word_t v);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        do @(posedge clk); while (!s_axis_tready);
        inverse_q.push_back(modinv_predict(v, modulus_shadow));
        burst_left--;
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        while (inverse_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_modulus(input word_t m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en      <= 1'b0;
        modulus_shadow = m;
    endtask

    // Receiver: checks each transfer, stalls on its own run-length pattern.
    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (inverse_q.size() == 0)
            begin
                $error("unexpected result: inverse %h no_inverse %b",
                       m_axis_tdata, m_axis_tuser);
                error_count++;
            end
            else
            begin
                if (m_axis_tdata !== inverse_q[0].inverse)
                begin
                    $error("inverse: expected %h actual %h",
                           inverse_q[0].inverse, m_axis_tdata);
                    error_count++;
                end
                if (m_axis_tuser !== inverse_q[0].no_inverse)
                begin
                    $error("no_inverse: expected %b actual %b",
                           inverse_q[0].no_inverse, m_axis_tuser);
                    error_count++;
                end
                void'(inverse_q.pop_front());
            end
        end
        if (ready_left == 0)
        begin
            if (m_axis_tready)
            begin
                m_axis_tready <= 1'b0;
                ready_left    = $urandom_range(1, 40);
            end
            else
            begin
                m_axis_tready <= 1'b1;
                ready_left    = ($urandom_range(0, 7) == 0) ? 3000 : $urandom_range(1, 60);
            end
        end
        else
        begin
            ready_left--;
        end
    end

    task automatic test_reset_modulus();
        send_value('0);
        send_value(64'd1);
        send_value(64'd3);
        send_value(ALL_ONES);
        send_value(HALF_RANGE);
        send_value(HALF_RANGE + 64'd1);
        drain_results();
    endtask

    task automatic test_tiny_moduli();
        write_modulus(64'd1);
        send_value('0);
        send_value(64'd5);
        send_value(ALL_ONES);
        drain_results();
        write_modulus('0);
        send_value(64'd3);
        send_value('0);
        drain_results();
        write_modulus(64'd2);
        send_value('0);
        send_value(64'd1);
        send_value(ALL_ONES);
        drain_results();
    endtask

    task automatic test_wide_moduli();
        write_modulus(ALL_ONES);
        send_value(ALL_ONES - 64'd1);
        send_value(ALL_ONES);
        send_value(64'd2);
        send_value(64'd3);
        drain_results();
        // consecutive Fibonacci numbers: longest Euclid chain
        write_modulus(FIB_93);
        send_value(FIB_92);
        send_value(64'd1);
        drain_results();
        write_modulus(MERSENNE61);
        send_value(ALL_ONES);
        send_value(MERSENNE61 - 64'd1);
        drain_results();
    endtask

    task automatic test_random_phases();
        int    sent;
        int    phase;
        int    n_items;
        int    w;
        word_t m;
        word_t v;
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_ITEMS)
        begin
            // full-width moduli are slow, so most phases use narrow ones
            if (phase == 0 || $urandom_range(0, 9) == 0)
            begin
                m       = {$urandom, $urandom};
                n_items = 40;
            end
            else
            begin
                w       = $urandom_range(2, 20);
                m       = ({$urandom, $urandom} & ((64'd1 << w) - 64'd1)) | (64'd1 << (w - 1));
                n_items = $urandom_range(60, 140);
            end
            if (m == '0)
                m = 64'd1;
            write_modulus(m);
            repeat (n_items)
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: v = {$urandom, $urandom};
                    6, 7:             v = {$urandom, $urandom} % m;
                    8:                v = m * $urandom_range(0, 5);
                    default:          v = m - 64'd1;
                endcase
                send_value(v);
            end
            sent += n_items;
            phase++;
            drain_results();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        cfg_wr_en     = 1'b0;
        cfg_wr_data   = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_modulus();
        test_tiny_moduli();
        test_wide_moduli();
        test_random_phases();
        drain_results();
        repeat (100) @(posedge clk);
        if (error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #500_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
